FILE: rtl/aps_pkg.sv
// Shared constants and types for the accelerometer pedometer step counter.
package aps_pkg;

	localparam int FILTER_SHIFT = 2;
	localparam int FILTER_COUNT = 1 << FILTER_SHIFT;
	localparam int AXES         = 3;
	localparam int SAMPLE_W     = 16;
	localparam int SUM_W        = SAMPLE_W + FILTER_SHIFT;
	localparam int GROUP_W      = (FILTER_SHIFT > 0) ? FILTER_SHIFT : 1;
	localparam int WIN_W        = 10;
	localparam int PREC_W       = 16;
	localparam int COUNT_W      = 32;
	localparam int AXIS_W       = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int IN_DATA_W    = 48;
	localparam int OUT_DATA_W   = 40;

	localparam logic [WIN_W-1:0]  WINDOW_LENGTH_RST     = WIN_W'(50);
	localparam logic [PREC_W-1:0] DYNAMIC_PRECISION_RST = PREC_W'(30);
	localparam logic [PREC_W-1:0] ACTIVE_PRECISION_RST  = PREC_W'(60);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [COUNT_W-1:0]         COUNT_MAX  = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH     = 2'd0,
		CFG_DYNAMIC_PRECISION = 2'd1,
		CFG_ACTIVE_PRECISION  = 2'd2
	} cfg_index_t;

	typedef enum logic [AXIS_W-1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

FILE: rtl/accel_pedometer_step_counter.sv
// Pedometer: averages raw three-axis samples and counts steps by peak/threshold.
// An accepted item passes through the input register and then the result register.
// Throughput: one item per cycle while the result side does not stall; the filter, window,
// slide and step logic compute all next state between the input register and the result register.
// Reset (arst_n low, asynchronous) clears all control state, counts and sums, and loads
// the default register values; the block takes items right after reset.
module accel_pedometer_step_counter
	import aps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PREC_W-1:0]     cfg_data,
	// raw samples
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
	// results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // step_seen[0], active_axis[2:1],
	                                             // step_total[34:3], zero pad[39:35]
	output logic                  m_axis_tuser   // average_done
);

	// configuration
	logic [WIN_W-1:0]  wlen_q;
	logic [PREC_W-1:0] dprec_q;
	logic [PREC_W-1:0] aprec_q;

	// input stage
	logic    valid_s1;
	sample_t accel_s1 [AXES];

	// detection state; the older slide value is always the newer one before its update
	logic signed [SUM_W-1:0] sum_q [AXES];
	logic [GROUP_W-1:0]      group_q;
	logic [WIN_W-1:0]        win_q;
	sample_t                 wmax_q [AXES];
	sample_t                 wmin_q [AXES];
	sample_t                 lmax_q [AXES];
	sample_t                 lmin_q [AXES];
	sample_t                 newer_q [AXES];
	logic [COUNT_W-1:0]      count_q;

	// result register
	logic               out_valid_q;
	logic               out_done_q;
	logic               out_seen_q;
	axis_t              out_axis_q;
	logic [COUNT_W-1:0] out_total_q;

	// next-state logic
	logic                    advance;
	logic                    group_last;
	logic signed [SUM_W-1:0] sum_n [AXES];
	logic signed [SUM_W:0]   biased [AXES];
	logic signed [SUM_W:0]   shifted [AXES];
	sample_t                 avg [AXES];
	logic [WIN_W:0]          win_inc;
	logic                    roll;
	logic [WIN_W-1:0]        win_n;
	sample_t                 base_max [AXES];
	sample_t                 base_min [AXES];
	sample_t                 wmax_n [AXES];
	sample_t                 wmin_n [AXES];
	sample_t                 lmax_n [AXES];
	sample_t                 lmin_n [AXES];
	logic signed [SAMPLE_W:0] diff [AXES];
	logic signed [SAMPLE_W:0] absd [AXES];
	sample_t                 newer_n [AXES];
	logic signed [SAMPLE_W:0] rng [AXES];
	logic signed [SAMPLE_W:0] aprec_s;
	axis_t                   axis;
	logic [1:0]              k;
	logic signed [SAMPLE_W:0] tsum;
	logic signed [SAMPLE_W:0] tsum_b;
	logic signed [SAMPLE_W:0] thr_w;
	sample_t                 thr;
	logic                    seen;
	logic [COUNT_W-1:0]      count_n;

	localparam logic signed [SUM_W:0] BIAS = (SUM_W+1)'(FILTER_COUNT - 1);

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign group_last    = (group_q == GROUP_W'(FILTER_COUNT - 1));

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum_n[a] = sum_q[a] + SUM_W'(accel_s1[a]);
			// truncate toward zero: bias negative sums before the arithmetic shift
			biased[a] = (SUM_W+1)'(sum_n[a]);
			if (sum_n[a][SUM_W-1]) begin
				biased[a] = biased[a] + BIAS;
			end
			shifted[a] = biased[a] >>> FILTER_SHIFT;
			avg[a]     = shifted[a][SAMPLE_W-1:0];
		end

		win_inc = (WIN_W+1)'(win_q) + (WIN_W+1)'(1);
		roll    = win_inc > (WIN_W+1)'(wlen_q);
		win_n   = roll ? WIN_W'(1) : win_inc[WIN_W-1:0];

		for (int a = 0; a < AXES; a++) begin
			base_max[a] = roll ? SAMPLE_MIN : wmax_q[a];
			base_min[a] = roll ? SAMPLE_MAX : wmin_q[a];
			wmax_n[a]   = (avg[a] > base_max[a]) ? avg[a] : base_max[a];
			wmin_n[a]   = (avg[a] < base_min[a]) ? avg[a] : base_min[a];
			lmax_n[a]   = roll ? wmax_q[a] : lmax_q[a];
			lmin_n[a]   = roll ? wmin_q[a] : lmin_q[a];

			diff[a]    = (SAMPLE_W+1)'(avg[a]) - (SAMPLE_W+1)'(newer_q[a]);
			absd[a]    = diff[a][SAMPLE_W] ? -diff[a] : diff[a];
			newer_n[a] = ($unsigned(absd[a]) > {1'b0, dprec_q}) ? avg[a] : newer_q[a];

			rng[a] = (SAMPLE_W+1)'(wmax_n[a]) - (SAMPLE_W+1)'(wmin_n[a]);
		end

		aprec_s = $signed({1'b0, aprec_q});
		if (rng[0] > rng[1] && rng[0] > rng[2] && rng[0] >= aprec_s) begin
			axis = AXIS_X;
		end else if (rng[1] > rng[0] && rng[1] > rng[2] && rng[1] >= aprec_s) begin
			axis = AXIS_Y;
		end else if (rng[2] > rng[0] && rng[2] > rng[1] && rng[2] >= aprec_s) begin
			axis = AXIS_Z;
		end else begin
			axis = AXIS_NONE;
		end

		k      = (axis == AXIS_NONE) ? 2'd0 : (axis - 2'd1);
		tsum   = (SAMPLE_W+1)'(lmax_n[k]) + (SAMPLE_W+1)'(lmin_n[k]);
		tsum_b = tsum + (tsum[SAMPLE_W] ? (SAMPLE_W+1)'(1) : '0);
		thr_w  = tsum_b >>> 1;
		thr    = thr_w[SAMPLE_W-1:0];
		// new older value (current newer) above the midpoint, new newer below: falling crossing
		seen   = (axis != AXIS_NONE) && (newer_q[k] > thr) && (newer_n[k] < thr);

		count_n = count_q;
		if (seen && (count_q != COUNT_MAX)) begin
			count_n = count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q  <= WINDOW_LENGTH_RST;
			dprec_q <= DYNAMIC_PRECISION_RST;
			aprec_q <= ACTIVE_PRECISION_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_LENGTH:     wlen_q  <= cfg_data[WIN_W-1:0];
				CFG_DYNAMIC_PRECISION: dprec_q <= cfg_data;
				CFG_ACTIVE_PRECISION:  aprec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			group_q     <= '0;
			win_q       <= '0;
			count_q     <= '0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a]   <= '0;
				wmax_q[a]  <= SAMPLE_MIN;
				wmin_q[a]  <= SAMPLE_MAX;
				lmax_q[a]  <= '0;
				lmin_q[a]  <= '0;
				newer_q[a] <= '0;
			end
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (advance) begin
				if (group_last) begin
					group_q <= '0;
					win_q   <= win_n;
					count_q <= count_n;
					for (int a = 0; a < AXES; a++) begin
						sum_q[a]   <= '0;
						wmax_q[a]  <= wmax_n[a];
						wmin_q[a]  <= wmin_n[a];
						lmax_q[a]  <= lmax_n[a];
						lmin_q[a]  <= lmin_n[a];
						newer_q[a] <= newer_n[a];
					end
				end else begin
					group_q <= group_q + GROUP_W'(1);
					for (int a = 0; a < AXES; a++) begin
						sum_q[a] <= sum_n[a];
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			accel_s1[0] <= s_axis_tdata[15:0];
			accel_s1[1] <= s_axis_tdata[31:16];
			accel_s1[2] <= s_axis_tdata[47:32];
		end
		if (advance) begin
			out_done_q  <= group_last;
			out_seen_q  <= group_last && seen;
			out_axis_q  <= group_last ? axis : AXIS_NONE;
			out_total_q <= group_last ? count_n : count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_done_q;
	assign m_axis_tdata  = {(OUT_DATA_W - COUNT_W - AXIS_W - 1)'(0), out_total_q,
		out_axis_q, out_seen_q};

endmodule

FILE: rtl/aps_checker.sv
// Port-level checker for the pedometer step counter, bound to the top level.
module aps_checker
	import aps_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser
);

	logic [COUNT_W-1:0] last_total_q;
	logic [COUNT_W-1:0] total;
	logic               seen;
	logic               out_acc;
	logic [COUNT_W-1:0] exp_total;

	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign seen    = m_axis_tdata[0];
	assign total   = m_axis_tdata[COUNT_W+AXIS_W:AXIS_W+1];
	assign exp_total = (seen && (last_total_q != COUNT_MAX))
		? last_total_q + COUNT_W'(1) : last_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (out_acc) begin
			last_total_q <= total;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result item changed while stalled");

	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !m_axis_tuser |-> m_axis_tdata[AXIS_W:0] == '0)
		else $error("item without averaged sample reports a step or an axis");

	a_seen_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && seen |-> m_axis_tdata[AXIS_W:1] != AXIS_NONE)
		else $error("step reported with no active axis");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> total == exp_total)
		else $error("step total does not follow step flags");

endmodule

bind accel_pedometer_step_counter aps_checker u_aps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the accelerometer pedometer step counter.
`timescale 1ns / 1ps

module tb_top;
	import aps_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 90;

	// Predicts the pedometer results and checks them in order.
	class step_scoreboard;
		typedef struct {
			bit                 done;
			bit                 seen;
			axis_t              axis;
			logic [COUNT_W-1:0] total;
		} step_result_t;

		int unsigned win_len, dyn_prec, act_prec;
		int          sum[3];
		int unsigned grp, win_idx;
		int          wmax[3], wmin[3], lmax[3], lmin[3], s_new[3], s_old[3];
		logic [COUNT_W-1:0] steps;
		step_result_t pending[$];
		int errors, checked, taken;

		function new();
			win_len  = WINDOW_LENGTH_RST;
			dyn_prec = DYNAMIC_PRECISION_RST;
			act_prec = ACTIVE_PRECISION_RST;
			grp      = 0;
			win_idx  = 0;
			steps    = '0;
			for (int a = 0; a < 3; a++) begin
				sum[a]   = 0;
				wmax[a]  = -32768;
				wmin[a]  = 32767;
				lmax[a]  = 0;
				lmin[a]  = 0;
				s_new[a] = 0;
				s_old[a] = 0;
			end
		endfunction

		function void write_reg(cfg_index_t idx, logic [PREC_W-1:0] v);
			case (idx)
				CFG_WINDOW_LENGTH:     win_len  = v[WIN_W-1:0];
				CFG_DYNAMIC_PRECISION: dyn_prec = v;
				CFG_ACTIVE_PRECISION:  act_prec = v;
				default: ;
			endcase
		endfunction

		function void note_input(sample_t x, sample_t y, sample_t z);
			int raw[3];
			int avg[3];
			int span[3];
			int d, k, mid;
			step_result_t r;
			raw[0] = x;
			raw[1] = y;
			raw[2] = z;
			taken++;
			for (int a = 0; a < 3; a++)
				sum[a] += raw[a];
			grp++;
			r.done  = 0;
			r.seen  = 0;
			r.axis  = AXIS_NONE;
			if (grp < FILTER_COUNT) begin
				r.total = steps;
				pending.push_back(r);
				return;
			end
			grp = 0;
			// int division truncates toward zero
			for (int a = 0; a < 3; a++) begin
				avg[a] = sum[a] / FILTER_COUNT;
				sum[a] = 0;
			end
			win_idx++;
			if (win_idx > win_len) begin
				win_idx = 1;
				for (int a = 0; a < 3; a++) begin
					lmax[a] = wmax[a];
					lmin[a] = wmin[a];
					wmax[a] = -32768;
					wmin[a] = 32767;
				end
			end
			for (int a = 0; a < 3; a++) begin
				if (avg[a] > wmax[a])
					wmax[a] = avg[a];
				if (avg[a] < wmin[a])
					wmin[a] = avg[a];
			end
			for (int a = 0; a < 3; a++) begin
				d = avg[a] - s_new[a];
				if (d < 0)
					d = -d;
				s_old[a] = s_new[a];
				if (d > int'(dyn_prec))
					s_new[a] = avg[a];
			end
			for (int a = 0; a < 3; a++)
				span[a] = wmax[a] - wmin[a];
			if (span[0] > span[1] && span[0] > span[2] && span[0] >= int'(act_prec))
				r.axis = AXIS_X;
			else if (span[1] > span[0] && span[1] > span[2] && span[1] >= int'(act_prec))
				r.axis = AXIS_Y;
			else if (span[2] > span[0] && span[2] > span[1] && span[2] >= int'(act_prec))
				r.axis = AXIS_Z;
			if (r.axis != AXIS_NONE) begin
				k   = int'(r.axis) - 1;
				mid = (lmax[k] + lmin[k]) / 2;
				if (s_old[k] > mid && s_new[k] < mid) begin
					r.seen = 1;
					if (steps != COUNT_MAX)
						steps++;
				end
			end
			r.done  = 1;
			r.total = steps;
			pending.push_back(r);
		endfunction

		function void check_result(logic done, logic [OUT_DATA_W-1:0] d);
			step_result_t r;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result: expected none actual tuser=%0b tdata=%0h",
					$time, done, d);
				errors++;
				return;
			end
			r = pending.pop_front();
			if (done !== r.done) begin
				$display("%0t: average_done mismatch: expected %0b actual %0b",
					$time, r.done, done);
				errors++;
			end
			if (d[0] !== r.seen) begin
				$display("%0t: step_seen mismatch: expected %0b actual %0b",
					$time, r.seen, d[0]);
				errors++;
			end
			if (d[2:1] !== r.axis) begin
				$display("%0t: active_axis mismatch: expected %0d actual %0d",
					$time, r.axis, d[2:1]);
				errors++;
			end
			if (d[34:3] !== r.total) begin
				$display("%0t: step_total mismatch: expected %0d actual %0d",
					$time, r.total, d[34:3]);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [PREC_W-1:0]     cfg_data;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	step_scoreboard sb = new();
	bit quiet = 1'b0;
	bit held  = 1'b0;
	int stall_cycles = 0;

	accel_pedometer_step_counter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// result side: random backpressure, one long hold-off to fill the pipeline
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= 400) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 32);
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input int x, input int y, input int z);
		while (!quiet && $urandom_range(99) < 32) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {sample_t'(z), sample_t'(y), sample_t'(x)};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(sample_t'(x), sample_t'(y), sample_t'(z));
		@(negedge clk);
	endtask

	task automatic write_cfg(input cfg_index_t idx, input logic [PREC_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		@(negedge clk);
	endtask

	// periodic motion on one axis, each averaged sample built from noisy raw items
	task automatic send_walk();
		int axis, amp, period, base, n, ph, tri_pos, level;
		int v[3];
		axis   = $urandom_range(2);
		amp    = $urandom_range(6000, 100);
		period = $urandom_range(12, 4);
		base   = int'($urandom_range(16000)) - 8000;
		n      = $urandom_range(24, 8);
		for (int i = 0; i < n; i++) begin
			ph      = i % period;
			tri_pos = (ph < period / 2) ? ph : period - ph;
			level   = base + amp * 2 * tri_pos / period;
			for (int r = 0; r < FILTER_COUNT; r++) begin
				for (int a = 0; a < 3; a++) begin
					v[a] = ((a == axis) ? level : base / 4) + int'($urandom_range(6)) - 3;
					if (v[a] > 32767)
						v[a] = 32767;
					else if (v[a] < -32768)
						v[a] = -32768;
				end
				send_item(v[0], v[1], v[2]);
			end
		end
	endtask

	task automatic random_phase(input int count);
		int start, pick;
		start = sb.taken;
		while (sb.taken - start < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_walk();
			end else if (pick < 85) begin
				repeat (FILTER_COUNT)
					send_item(int'($urandom_range(65535)), int'($urandom_range(65535)),
						int'($urandom_range(65535)));
			end else begin
				// short burst that shifts the averaging group boundary
				repeat ($urandom_range(3, 1))
					send_item(int'($urandom_range(65535)), int'($urandom_range(65535)),
						int'($urandom_range(65535)));
			end
		end
	endtask

	// called at a falling edge with the input side idle
	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int unsigned settings [7][3];
		settings = '{'{1023, 0, 0}, '{3, 30, 60}, '{0, 65535, 65535}, '{1, 0, 65535},
			'{8, 20, 100}, '{16, 50, 200}, '{5, 10, 0}};
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_WINDOW_LENGTH;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes of the input range
		repeat (4) send_item(32767, 32767, 32767);
		repeat (4) send_item(-32768, -32768, -32768);
		// negative sums truncate toward zero
		for (int i = 0; i < 4; i++)
			send_item(i < 3 ? -1 : 0, i < 3 ? 1 : 0, i < 2 ? -2 : -1);
		// equal ranges on all axes: no active axis
		repeat (4) send_item(1000, 1000, 1000);
		for (int i = 0; i < 4; i++)
			send_item(i[0] ? -32768 : 32767, 0, -1);
		random_phase(PHASE_ITEMS);
		s_axis_tvalid <= 1'b0;
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p < 7) begin
				write_cfg(CFG_WINDOW_LENGTH, PREC_W'(settings[p][0]));
				write_cfg(CFG_DYNAMIC_PRECISION, PREC_W'(settings[p][1]));
				write_cfg(CFG_ACTIVE_PRECISION, PREC_W'(settings[p][2]));
			end else begin
				write_cfg(CFG_WINDOW_LENGTH, PREC_W'($urandom_range(40, 1)));
				write_cfg(CFG_DYNAMIC_PRECISION, PREC_W'($urandom_range(300)));
				write_cfg(CFG_ACTIVE_PRECISION, PREC_W'($urandom_range(3000)));
			end
			cfg_valid <= 1'b0;
			quiet = (p == 1 || p == 4);
			random_phase(PHASE_ITEMS);
			s_axis_tvalid <= 1'b0;
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
